// ===== sv/cfft_pkg.sv =====
package cfft_pkg;

  localparam int unsigned MaxBlocks = 1024;
  localparam int unsigned MaxFiles  = 64;
  localparam logic [10:0] DiskReset = 11'd1024;

  typedef enum logic [1:0] {
    FN_CREATE  = 2'd0,
    FN_DELETE  = 2'd1,
    FN_PRELOAD = 2'd2,
    FN_ALT     = 2'd3
  } func_e;

  typedef enum logic [2:0] {
    STS_CREATED   = 3'd0,
    STS_DELETED   = 3'd1,
    STS_PRELOADED = 3'd2,
    STS_NOSPACE   = 3'd3,
    STS_DENIED    = 3'd4,
    STS_NOTFOUND  = 3'd5
  } status_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIT,
    ST_FIND,
    ST_SHIFT
  } state_e;

  localparam logic [0:0] RegDiskBlocks = 1'd0;

  // One table entry as stored in the memory.
  typedef struct packed {
    logic [7:0]  name;
    logic [9:0]  start;
    logic [10:0] len;
    logic [7:0]  pid;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef struct packed {
    func_e       func;
    logic [7:0]  file_name;
    logic [10:0] block_count;
    logic [9:0]  start_block;
    logic [7:0]  pid;
    logic        privileged;
    logic [15:0] op_tag;
  } req_t;

  typedef struct packed {
    logic [15:0] op_tag_out;
    status_e     status;
    logic [9:0]  first_block;
    logic [9:0]  last_block;
  } res_t;

endpackage

// ===== sv/cfft_mem.sv =====
module cfft_mem
  import cfft_pkg::*;
#(
  parameter int unsigned Depth = MaxFiles
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  entry_t                   wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output entry_t                   rdata_o
);

  entry_t mem_q [Depth];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/cfft_engine.sv =====
module cfft_engine
  import cfft_pkg::*;
#(
  parameter int unsigned Depth = MaxFiles
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     req_valid_i,
  input  req_t                     req_i,
  output logic                     req_ready_o,
  input  logic                     out_busy_i,
  input  logic [10:0]              disk_i,
  output logic                     res_valid_o,
  output res_t                     res_o,
  output logic                     mem_we_o,
  output logic [$clog2(Depth)-1:0] mem_waddr_o,
  output entry_t                   mem_wdata_o,
  output logic [$clog2(Depth)-1:0] mem_raddr_o,
  input  entry_t                   mem_rdata_i
);

  localparam int unsigned IdxW = $clog2(Depth);
  localparam int unsigned CntW = IdxW + 1;
  localparam logic [CntW-1:0] CntMax = CntW'(Depth);

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [IdxW-1:0] rd_idx_q, rd_idx_d;
  logic [IdxW-1:0] dat_idx_q, dat_idx_d;
  logic            dat_vld_q, dat_vld_d;
  logic            chg_q, chg_d;
  logic [11:0]     s_q, s_d;
  req_t            req_q, req_d;

  logic        acc;
  logic [10:0] disk_eff;
  logic [12:0] hi;
  logic [11:0] jump;
  logic [11:0] ent_last;
  logic        ovl, ovl_past, last_ent, name_hit, allow;
  logic        full, bad_count;

  always_comb begin
    if (32'(disk_i) > MaxBlocks) begin
      disk_eff = 11'(MaxBlocks);
    end else begin
      disk_eff = disk_i;
    end
  end

  assign req_ready_o = (state_q == ST_IDLE) && !out_busy_i;
  assign acc         = req_valid_i && req_ready_o;
  assign full        = (cnt_q >= CntMax);
  assign bad_count   = (req_i.block_count == 11'd0) || (req_i.block_count > disk_eff);

  // Candidate run is [s, hi]; an entry overlaps when it starts at or below hi and
  // ends at or above s. The next candidate then starts just past that entry.
  assign hi       = 13'(s_q) + 13'(req_q.block_count) - 13'd1;
  assign jump     = 12'(mem_rdata_i.start) + 12'(mem_rdata_i.len);
  assign ent_last = jump - 12'd1;
  assign ovl      = (mem_rdata_i.len != 11'd0) && (13'(mem_rdata_i.start) <= hi)
                    && (ent_last >= s_q);
  assign ovl_past = (13'(jump) + 13'(req_q.block_count)) > 13'(disk_eff);
  assign last_ent = (dat_idx_q == IdxW'(cnt_q - CntW'(1)));
  assign name_hit = (mem_rdata_i.name == req_q.file_name);
  assign allow    = req_q.privileged || (mem_rdata_i.pid == req_q.pid);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (req_i.func)
            FN_DELETE: begin
              if (cnt_q != '0) state_d = ST_FIND;
            end
            FN_PRELOAD: state_d = ST_IDLE;
            default: begin
              if (!full && !bad_count && cnt_q != '0) state_d = ST_FIT;
            end
          endcase
        end
      end
      ST_FIT: begin
        if (dat_vld_q) begin
          if (ovl && ovl_past) state_d = ST_IDLE;
          else if (last_ent && !ovl && !chg_q) state_d = ST_IDLE;
        end
      end
      ST_FIND: begin
        if (dat_vld_q) begin
          if (name_hit) state_d = (allow && !last_ent) ? ST_SHIFT : ST_IDLE;
          else if (last_ent) state_d = ST_IDLE;
        end
      end
      ST_SHIFT: begin
        if (dat_vld_q && last_ent) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    dat_idx_d   = dat_idx_q;
    dat_vld_d   = dat_vld_q;
    chg_d       = chg_q;
    s_d         = s_q;
    req_d       = req_q;
    res_valid_o = 1'b0;
    res_o       = '{op_tag_out: req_q.op_tag, status: STS_NOSPACE,
                    first_block: 10'd0, last_block: 10'd0};
    mem_we_o    = 1'b0;
    mem_waddr_o = IdxW'(cnt_q);
    mem_wdata_o = '{name: req_q.file_name, start: s_q[9:0], len: req_q.block_count,
                    pid: req_q.pid};
    mem_raddr_o = rd_idx_q;
    case (state_q)
      ST_IDLE: begin
        rd_idx_d  = '0;
        dat_vld_d = 1'b0;
        chg_d     = 1'b0;
        s_d       = '0;
        if (acc) begin
          req_d            = req_i;
          res_o.op_tag_out = req_i.op_tag;
          case (req_i.func)
            FN_PRELOAD: begin
              res_valid_o = 1'b1;
              if (!full) begin
                mem_we_o     = 1'b1;
                mem_wdata_o  = '{name: req_i.file_name, start: req_i.start_block,
                                 len: req_i.block_count, pid: req_i.pid};
                cnt_d        = cnt_q + CntW'(1);
                res_o.status = STS_PRELOADED;
              end
            end
            FN_DELETE: begin
              if (cnt_q == '0) begin
                res_valid_o  = 1'b1;
                res_o.status = STS_NOTFOUND;
              end
            end
            default: begin
              if (full || bad_count) begin
                res_valid_o = 1'b1;
              end else if (cnt_q == '0) begin
                // Empty table: the file goes at block zero.
                res_valid_o       = 1'b1;
                mem_we_o          = 1'b1;
                mem_wdata_o       = '{name: req_i.file_name, start: 10'd0,
                                      len: req_i.block_count, pid: req_i.pid};
                cnt_d             = cnt_q + CntW'(1);
                res_o.status      = STS_CREATED;
                res_o.last_block  = 10'(req_i.block_count - 11'd1);
              end
            end
          endcase
        end
      end
      ST_FIT: begin
        dat_vld_d = 1'b1;
        dat_idx_d = rd_idx_q;
        rd_idx_d  = (rd_idx_q == IdxW'(cnt_q - CntW'(1))) ? '0 : rd_idx_q + IdxW'(1);
        if (dat_vld_q) begin
          if (ovl) begin
            s_d   = jump;
            chg_d = !last_ent;
            if (ovl_past) res_valid_o = 1'b1;
          end else if (last_ent) begin
            if (chg_q) begin
              chg_d = 1'b0;
            end else begin
              res_valid_o       = 1'b1;
              mem_we_o          = 1'b1;
              cnt_d             = cnt_q + CntW'(1);
              res_o.status      = STS_CREATED;
              res_o.first_block = s_q[9:0];
              res_o.last_block  = hi[9:0];
            end
          end
        end
      end
      ST_FIND: begin
        dat_vld_d = 1'b1;
        dat_idx_d = rd_idx_q;
        rd_idx_d  = rd_idx_q + IdxW'(1);
        if (dat_vld_q) begin
          if (name_hit) begin
            if (!allow) begin
              res_valid_o  = 1'b1;
              res_o.status = STS_DENIED;
            end else if (last_ent) begin
              res_valid_o  = 1'b1;
              cnt_d        = cnt_q - CntW'(1);
              res_o.status = STS_DELETED;
            end
          end else if (last_ent) begin
            res_valid_o  = 1'b1;
            res_o.status = STS_NOTFOUND;
          end
        end
      end
      ST_SHIFT: begin
        // Each entry read moves one place down to close the gap.
        dat_vld_d = 1'b1;
        dat_idx_d = rd_idx_q;
        rd_idx_d  = rd_idx_q + IdxW'(1);
        if (dat_vld_q) begin
          mem_we_o    = 1'b1;
          mem_waddr_o = dat_idx_q - IdxW'(1);
          mem_wdata_o = mem_rdata_i;
          if (last_ent) begin
            res_valid_o  = 1'b1;
            cnt_d        = cnt_q - CntW'(1);
            res_o.status = STS_DELETED;
          end
        end
      end
      default: begin
        dat_vld_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      dat_vld_q <= 1'b0;
      chg_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      dat_vld_q <= dat_vld_d;
      chg_q     <= chg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q  <= rd_idx_d;
    dat_idx_q <= dat_idx_d;
    s_q       <= s_d;
    req_q     <= req_d;
  end

endmodule

// ===== sv/contiguous_first_fit_file_table.sv =====
// File table with first-fit contiguous block allocation.
// Requests arrive on the s_axis channel: tuser carries the function (create,
// delete, preload; the fourth code acts as create), tdata the name, block
// count, start, pid, privilege and tag. One result per request leaves on
// m_axis with the tag, status and the first and last block of a created file.
// The table lives in a single memory with a registered read port. A preload, or
// a request that is answered without reading the table, gives its result in the
// cycle after it is taken. A delete reads the table once, one entry per cycle,
// and moves the entries above the deleted one down as the reads go on.
// A create makes passes over the table; every entry that overlaps the
// candidate run moves the candidate past it, and a pass with no overlap ends
// the search, as does a candidate that would run past the end of the disk.
// A new request is taken only when the engine is idle and the result register
// is empty, so it is not taken before the last result has left; a stalled
// m_axis receiver holds the result and blocks new requests.
// Reset empties the table and sets disk_blocks to 1024; the memory needs no
// clearing since entries above the count are never used.
// disk_blocks is written through the APB port at address 0.
module contiguous_first_fit_file_table
  import cfft_pkg::*;
#(
  parameter int unsigned MaxFilesP = MaxFiles
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [7:0] file_name, [18:8] block_count, [28:19] start_block, [36:29] pid,
  // [37] privileged, [53:38] op_tag, [55:54] zero
  input  logic [55:0] s_axis_tdata_i,
  // [1:0] func
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [15:0] op_tag_out, [18:16] status, [28:19] first_block, [38:29] last_block,
  // [39] zero
  output logic [39:0] m_axis_tdata_o,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [2:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  output logic [31:0] prdata_o,
  output logic        pready_o
);

  localparam int unsigned IdxW = $clog2(MaxFilesP);

  logic [10:0]     disk_q, disk_d;
  logic            out_vld_q, out_vld_d;
  res_t            out_q, out_d;
  req_t            req;
  logic            res_valid;
  res_t            res;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  entry_t          mem_wdata, mem_rdata;
  logic            reg_sel;

  assign req = '{func: func_e'(s_axis_tuser_i), file_name: s_axis_tdata_i[7:0],
                 block_count: s_axis_tdata_i[18:8], start_block: s_axis_tdata_i[28:19],
                 pid: s_axis_tdata_i[36:29], privileged: s_axis_tdata_i[37],
                 op_tag: s_axis_tdata_i[53:38]};

  assign reg_sel  = (paddr_i[2] == RegDiskBlocks) && (paddr_i[1:0] == 2'd0);
  assign pready_o = 1'b1;
  assign prdata_o = reg_sel ? {21'd0, disk_q} : 32'd0;

  always_comb begin
    disk_d = disk_q;
    if (psel_i && penable_i && pwrite_i && reg_sel) disk_d = pwdata_i[10:0];
  end

  always_comb begin
    out_vld_d = out_vld_q;
    out_d     = out_q;
    if (m_axis_tready_i) out_vld_d = 1'b0;
    if (res_valid) begin
      out_vld_d = 1'b1;
      out_d     = res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      disk_q    <= DiskReset;
      out_vld_q <= 1'b0;
    end else begin
      disk_q    <= disk_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, out_q.last_block, out_q.first_block, out_q.status,
                            out_q.op_tag_out};

  cfft_engine #(
    .Depth(MaxFilesP)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_i       (req),
    .req_ready_o (s_axis_tready_o),
    .out_busy_i  (out_vld_q),
    .disk_i      (disk_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  cfft_mem #(
    .Depth(MaxFilesP)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
